// ----- sv/phc_pkg.sv -----
// Package for the packet header classifier.
// Holds word types, protocol constants, result codes and the ones' complement adder.
// No dependencies.
package phc_pkg;

	localparam logic [15:0] ETYPE_ARP     = 16'h0806;
	localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP    = 8'h01;
	localparam logic [7:0]  PROTO_UDP     = 8'h11;
	localparam logic [7:0]  PROTO_TCP     = 8'h06;
	localparam logic [7:0]  ICMP_ECHO_REQ = 8'h08;
	localparam logic [7:0]  ICMP_ECHO_REP = 8'h00;
	localparam logic [15:0] ARPOP_REQ     = 16'h0001;
	localparam logic [15:0] ARPOP_REP     = 16'h0002;
	localparam logic [7:0]  TCPF_SYN      = 8'h02;
	localparam logic [7:0]  TCPF_RST      = 8'h04;
	localparam logic [7:0]  TCPF_FIN      = 8'h01;
	localparam logic [3:0]  IHL_MASK      = 4'hf;
	localparam logic [3:0]  IHL_MIN       = 4'd5;

	localparam logic [15:0] ETH_LEN       = 16'd14;
	localparam logic [15:0] POS_ETYPE     = 16'd13;
	localparam logic [15:0] POS_ARP_OP    = 16'd21;
	localparam logic [15:0] POS_MAX       = 16'hffff;
	localparam logic [16:0] ARP_LEN       = 17'd42;
	localparam logic [16:0] L4_MIN_LEN    = 17'd8;
	localparam logic [16:0] TCP_HDR_LEN   = 17'd20;
	localparam logic [5:0]  IP_HDR_MIN    = 6'd20;

	localparam logic [15:0] Q_IHL         = 16'd0;
	localparam logic [15:0] Q_TLEN        = 16'd3;
	localparam logic [15:0] Q_TTL         = 16'd8;
	localparam logic [15:0] Q_PROTO       = 16'd9;
	localparam logic [15:0] Q_ADDR_LO     = 16'd12;
	localparam logic [15:0] Q_ADDR_HI     = 16'd20;

	localparam logic [15:0] R_ICMP_TYPE   = 16'd0;
	localparam logic [15:0] R_SRC_PORT    = 16'd1;
	localparam logic [15:0] R_DST_PORT    = 16'd3;
	localparam logic [15:0] R_TCP_FLAGS   = 16'd13;
	localparam logic [15:0] R_WINDOW      = 16'd15;

	localparam logic [1:0]  KIND_ARP      = 2'd0;
	localparam logic [1:0]  KIND_IPV4     = 2'd1;
	localparam logic [1:0]  KIND_OTHER    = 2'd2;
	localparam logic [1:0]  ARPK_REQ      = 2'd0;
	localparam logic [1:0]  ARPK_REP      = 2'd1;
	localparam logic [1:0]  ARPK_OTHER    = 2'd2;
	localparam logic [1:0]  ICMPK_REQ     = 2'd0;
	localparam logic [1:0]  ICMPK_REP     = 2'd1;
	localparam logic [1:0]  ICMPK_OTHER   = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} phc_in_t;

	typedef struct packed {
		logic [1:0]  frame_kind;
		logic [1:0]  arp_op_kind;
		logic [7:0]  ip_protocol;
		logic [7:0]  ttl_byte;
		logic        ip_header_ok;
		logic [1:0]  icmp_kind;
		logic [15:0] src_port;
		logic [15:0] dest_port;
		logic [2:0]  tcp_flag_bits;
		logic [15:0] tcp_window;
		logic        tcp_checksum_ok;
		logic        truncated;
	} phc_out_t;

	typedef struct packed {
		logic [15:0] pos;
		logic [15:0] etype;
		logic [5:0]  hlen;
		logic [15:0] tlen;
		logic [7:0]  proto;
		logic [15:0] ip_sum;
		logic [15:0] seg_sum;
		logic [7:0]  ttl;
		logic [15:0] f16;
		logic [15:0] dport;
		logic [2:0]  flags;
		logic [15:0] window;
	} phc_state_t;

	function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, v};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

// ----- sv/phc_parse.sv -----
// Byte parser: input register and per-frame running state.
// Hands the frame state to the finishing stage on the last byte.
// Depends on phc_pkg.
module phc_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  phc_pkg::phc_in_t    byte_word,
	output logic                snap_valid,
	input  logic                snap_ready,
	output phc_pkg::phc_state_t snap
);
	import phc_pkg::*;

	logic        valid_s1;
	phc_in_t     word_s1;
	phc_state_t  st_q;
	logic [7:0]  hold_q;
	logic        adv;

	logic [7:0]  b;
	logic [15:0] q;
	logic [15:0] r;
	logic [15:0] word;
	logic [15:0] part;
	logic [5:0]  hl_new;
	logic [5:0]  hl_eff;
	logic        is_ip;
	phc_state_t  nxt;

	assign adv        = valid_s1 && (!word_s1.last_byte || snap_ready);
	assign byte_ready = !valid_s1 || adv;
	assign snap_valid = valid_s1 && word_s1.last_byte;
	assign snap       = nxt;

	always_comb begin
		b      = word_s1.data_byte;
		word   = {hold_q, b};
		part   = st_q.pos[0] ? {8'h00, b} : {b, 8'h00};
		q      = st_q.pos - ETH_LEN;
		hl_new = ((b[3:0] & IHL_MASK) < IHL_MIN) ? IP_HDR_MIN : {b[3:0] & IHL_MASK, 2'b00};
		hl_eff = (q == Q_IHL) ? hl_new : st_q.hlen;
		r      = q - {10'd0, hl_eff};
		is_ip  = (st_q.etype == ETYPE_IPV4) && (st_q.pos >= ETH_LEN);
		nxt    = st_q;
		if (st_q.pos != POS_MAX) begin
			nxt.pos = st_q.pos + 16'd1;
			if (st_q.pos == POS_ETYPE)
				nxt.etype = word;
			if (st_q.etype == ETYPE_ARP && st_q.pos == POS_ARP_OP)
				nxt.f16 = word;
			if (is_ip) begin
				if (q == Q_IHL)
					nxt.hlen = hl_new;
				if (q == Q_TLEN)
					nxt.tlen = word;
				if (q == Q_TTL)
					nxt.ttl = b;
				if (q == Q_PROTO)
					nxt.proto = b;
				if (q < {10'd0, hl_eff})
					nxt.ip_sum = oc_add(st_q.ip_sum, part);
				if ((q >= Q_ADDR_LO && q < Q_ADDR_HI) ||
				    (q >= {10'd0, hl_eff} && q < st_q.tlen))
					nxt.seg_sum = oc_add(st_q.seg_sum, part);
				if (q >= {10'd0, hl_eff}) begin
					if (st_q.proto == PROTO_ICMP && r == R_ICMP_TYPE)
						nxt.f16 = {8'h00, b};
					if (st_q.proto == PROTO_TCP || st_q.proto == PROTO_UDP) begin
						if (r == R_SRC_PORT)
							nxt.f16 = word;
						if (r == R_DST_PORT)
							nxt.dport = word;
					end
					if (st_q.proto == PROTO_TCP) begin
						if (r == R_TCP_FLAGS)
							nxt.flags = {|(b & TCPF_SYN), |(b & TCPF_RST), |(b & TCPF_FIN)};
						if (r == R_WINDOW)
							nxt.window = word;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready)
			word_s1 <= byte_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			hold_q <= '0;
		end else if (adv) begin
			if (word_s1.last_byte) begin
				st_q   <= '0;
				hold_q <= '0;
			end else begin
				st_q <= nxt;
				if (st_q.pos != POS_MAX)
					hold_q <= word_s1.data_byte;
			end
		end
	end

endmodule

// ----- sv/phc_finish.sv -----
// Finishing stage: registers the frame state, derives lengths, checks and codes,
// and holds the result word for the output channel.
// Depends on phc_pkg.
module phc_finish (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                snap_valid,
	output logic                snap_ready,
	input  phc_pkg::phc_state_t snap,
	output logic                result_valid,
	input  logic                result_ready,
	output phc_pkg::phc_out_t   result_word
);
	import phc_pkg::*;

	logic        valid_s2;
	phc_state_t  st_s2;
	logic        valid_q;
	phc_out_t    res_q;
	logic        out_adv;

	logic [5:0]  hl;
	logic [15:0] hl16;
	logic [16:0] pos17;
	logic [16:0] ip_end;
	logic [16:0] tcp_a;
	logic [16:0] tcp_c;
	logic [16:0] need;
	logic        is_arp;
	logic        is_ip;
	logic        is_tcp;
	logic        is_icmp;
	logic        has_ports;
	logic        trunc;
	logic [15:0] seg_len;
	logic [15:0] sum_p;
	logic [15:0] sum_f;
	phc_out_t    res;

	assign out_adv      = valid_s2 && (!valid_q || result_ready);
	assign snap_ready   = !valid_s2 || out_adv;
	assign result_valid = valid_q;
	assign result_word  = res_q;

	always_comb begin
		hl        = (st_s2.hlen < IP_HDR_MIN) ? IP_HDR_MIN : st_s2.hlen;
		hl16      = {10'd0, hl};
		pos17     = {1'b0, st_s2.pos};
		is_arp    = st_s2.etype == ETYPE_ARP;
		is_ip     = st_s2.etype == ETYPE_IPV4;
		is_tcp    = is_ip && st_s2.proto == PROTO_TCP;
		is_icmp   = is_ip && st_s2.proto == PROTO_ICMP;
		has_ports = is_ip && (st_s2.proto == PROTO_TCP || st_s2.proto == PROTO_UDP);
		ip_end    = {1'b0, ETH_LEN} + {11'd0, hl};
		tcp_a     = ip_end + TCP_HDR_LEN;
		tcp_c     = {1'b0, ETH_LEN} + {1'b0, st_s2.tlen};
		need      = {1'b0, ETH_LEN};
		if (is_arp)
			need = ARP_LEN;
		if (is_ip) begin
			need = ip_end;
			if (st_s2.proto == PROTO_ICMP || st_s2.proto == PROTO_UDP)
				need = ip_end + L4_MIN_LEN;
			if (is_tcp)
				need = (tcp_a > tcp_c) ? tcp_a : tcp_c;
		end
		trunc   = pos17 < need;
		seg_len = st_s2.tlen - hl16;
		sum_p   = oc_add(st_s2.seg_sum, {8'h00, PROTO_TCP});
		sum_f   = oc_add(sum_p, seg_len);

		res.frame_kind      = is_arp ? KIND_ARP : (is_ip ? KIND_IPV4 : KIND_OTHER);
		res.arp_op_kind     = ARPK_OTHER;
		if (is_arp) begin
			if (st_s2.f16 == ARPOP_REQ)
				res.arp_op_kind = ARPK_REQ;
			else if (st_s2.f16 == ARPOP_REP)
				res.arp_op_kind = ARPK_REP;
		end
		res.ip_protocol     = is_ip ? st_s2.proto : 8'h00;
		res.ttl_byte        = is_ip ? st_s2.ttl : 8'h00;
		res.ip_header_ok    = is_ip && pos17 >= ip_end && st_s2.ip_sum == 16'hffff;
		res.icmp_kind       = ICMPK_OTHER;
		if (is_icmp) begin
			if (st_s2.f16[7:0] == ICMP_ECHO_REQ)
				res.icmp_kind = ICMPK_REQ;
			else if (st_s2.f16[7:0] == ICMP_ECHO_REP)
				res.icmp_kind = ICMPK_REP;
		end
		res.src_port        = has_ports ? st_s2.f16 : 16'h0000;
		res.dest_port       = has_ports ? st_s2.dport : 16'h0000;
		res.tcp_flag_bits   = is_tcp ? st_s2.flags : 3'd0;
		res.tcp_window      = is_tcp ? st_s2.window : 16'h0000;
		res.tcp_checksum_ok = is_tcp && !trunc && st_s2.tlen >= hl16 && sum_f == 16'hffff;
		res.truncated       = trunc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (snap_ready)
				valid_s2 <= snap_valid;
			if (!valid_q || result_ready)
				valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready)
			st_s2 <= snap;
		if (out_adv)
			res_q <= res;
	end

endmodule

// ----- sv/packet_header_classifier.sv -----
// Packet header classifier top level: byte parser followed by the finishing stage.
// A last byte's result word passes through the parser input, finishing and result registers.
// Throughput: one byte per cycle unless stalled; the running sums take one byte each cycle.
// Reset clears the frame state and all valid flags; the state clears again after each frame.
// Depends on phc_pkg, phc_parse and phc_finish.
module packet_header_classifier (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  phc_pkg::phc_in_t  byte_word,
	output logic              result_valid,
	input  logic              result_ready,
	output phc_pkg::phc_out_t result_word
);
	import phc_pkg::*;

	logic       snap_valid;
	logic       snap_ready;
	phc_state_t snap;

	phc_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_word  (byte_word),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	phc_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap         (snap),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

	a_tcp_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.tcp_checksum_ok |->
			!result_word.truncated && result_word.frame_kind == KIND_IPV4 &&
			result_word.ip_protocol == PROTO_TCP)
		else $error("tcp checksum ok on a truncated or non-tcp frame");

	a_non_ip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.frame_kind != KIND_IPV4 |->
			result_word.ip_protocol == 8'h00 && result_word.ttl_byte == 8'h00 &&
			!result_word.ip_header_ok && result_word.src_port == 16'h0000)
		else $error("ip fields set on a non-ip frame");

	a_icmp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.icmp_kind != ICMPK_OTHER |->
			result_word.ip_protocol == PROTO_ICMP)
		else $error("icmp kind on a non-icmp frame");

	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid && !snap_ready |=> snap_valid && $stable(snap))
		else $error("frame state changed while waiting for the finishing stage");

endmodule

// ----- dv/tb_top.sv -----
// Regression bench for packet_header_classifier: directed and random Ethernet frames
// sent byte by byte, results checked against a built-in frame classifier.
// Depends on phc_pkg and the packet_header_classifier RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import phc_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     byte_valid = 1'b0;
	logic     byte_ready;
	phc_in_t  byte_word = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	phc_out_t result_word;

	packet_header_classifier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_word   (byte_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_word (result_word)
	);

	always #5 clk = ~clk;

	logic [7:0] frame_buf[$];
	phc_out_t   frame_results[$];
	bit         idle_on = 1'b1;
	int         hold_off = 0;
	int         field_errors = 0;
	int         bytes_sent = 0;
	int         frames_sent = 0;
	int         results_seen = 0;
	int         arp_seen = 0;
	int         ipv4_seen = 0;
	int         trunc_seen = 0;
	int         tcp_ok_seen = 0;

	logic [15:0] pos_cnt;
	logic [15:0] etype_r;
	logic [5:0]  hdr_len;
	logic [15:0] tot_len;
	logic [7:0]  proto_r;
	logic [15:0] hsum;
	logic [15:0] ssum;
	logic [7:0]  prev_byte;
	logic [7:0]  cap_ttl;
	logic [15:0] cap_f16;
	logic [15:0] cap_dport;
	logic [2:0]  cap_flags;
	logic [15:0] cap_window;

	function automatic logic [15:0] csum_add(input logic [15:0] s, input logic [15:0] v);
		int unsigned t;
		t = 32'(s) + 32'(v);
		t = (t & 32'hffff) + (t >> 16);
		return t[15:0];
	endfunction

	function automatic void clear_parser();
		pos_cnt = '0;
		etype_r = '0;
		hdr_len = '0;
		tot_len = '0;
		proto_r = '0;
		hsum = '0;
		ssum = '0;
		prev_byte = '0;
		cap_ttl = '0;
		cap_f16 = '0;
		cap_dport = '0;
		cap_flags = '0;
		cap_window = '0;
	endfunction

	initial clear_parser();

	function automatic bit classify_byte(input logic [7:0] d, input logic l, output phc_out_t res);
		int unsigned p, q, r, n, hl, need, a, c;
		logic [15:0] w, part, s;
		bit ipv4, tcp, l4, trunc, hok, tok;
		p = 32'(pos_cnt);
		res = '0;
		if (p < 32'hffff) begin
			w = {prev_byte, d};
			part = p[0] ? {8'h00, d} : {d, 8'h00};
			if (p == 13) etype_r = w;
			if (p == 21 && etype_r == ETYPE_ARP) cap_f16 = w;
			if (p >= 14 && etype_r == ETYPE_IPV4) begin
				q = p - 14;
				if (q == 0) hdr_len = (d[3:0] < 4'd5) ? 6'd20 : {d[3:0], 2'b00};
				if (q == 3) tot_len = w;
				if (q == 8) cap_ttl = d;
				if (q == 9) proto_r = d;
				if (q < 32'(hdr_len)) hsum = csum_add(hsum, part);
				if (q >= 12 && q < 20) ssum = csum_add(ssum, part);
				if (q >= 32'(hdr_len)) begin
					r = q - 32'(hdr_len);
					if (q < 32'(tot_len)) ssum = csum_add(ssum, part);
					if (proto_r == PROTO_ICMP && r == 0) cap_f16 = {8'h00, d};
					if (proto_r == PROTO_TCP || proto_r == PROTO_UDP) begin
						if (r == 1) cap_f16 = w;
						if (r == 3) cap_dport = w;
					end
					if (proto_r == PROTO_TCP) begin
						if (r == 13)
							cap_flags = {|(d & TCPF_SYN), |(d & TCPF_RST), |(d & TCPF_FIN)};
						if (r == 15) cap_window = w;
					end
				end
			end
			prev_byte = d;
			pos_cnt = 16'(p + 1);
		end
		if (!l) return 1'b0;

		n = 32'(pos_cnt);
		hl = (hdr_len < 6'd20) ? 20 : 32'(hdr_len);
		ipv4 = etype_r == ETYPE_IPV4;
		tcp = ipv4 && proto_r == PROTO_TCP;
		l4 = tcp || (ipv4 && proto_r == PROTO_UDP);
		hok = 1'b0;
		tok = 1'b0;
		need = 14;
		if (etype_r == ETYPE_ARP) need = 42;
		if (ipv4) begin
			need = 14 + hl;
			if (proto_r == PROTO_ICMP || proto_r == PROTO_UDP) need += 8;
			if (tcp) begin
				a = 14 + hl + 20;
				c = 14 + 32'(tot_len);
				need = (a > c) ? a : c;
			end
			hok = (n >= 14 + hl) && hsum == 16'hffff;
		end
		trunc = n < need;
		if (tcp && !trunc && 32'(tot_len) >= hl) begin
			s = csum_add(ssum, {8'h00, PROTO_TCP});
			s = csum_add(s, 16'(32'(tot_len) - hl));
			tok = s == 16'hffff;
		end

		res.frame_kind = (etype_r == ETYPE_ARP) ? KIND_ARP : (ipv4 ? KIND_IPV4 : KIND_OTHER);
		res.arp_op_kind = ARPK_OTHER;
		if (etype_r == ETYPE_ARP) begin
			if (cap_f16 == ARPOP_REQ) res.arp_op_kind = ARPK_REQ;
			else if (cap_f16 == ARPOP_REP) res.arp_op_kind = ARPK_REP;
		end
		res.icmp_kind = ICMPK_OTHER;
		if (ipv4 && proto_r == PROTO_ICMP) begin
			if (cap_f16[7:0] == ICMP_ECHO_REQ) res.icmp_kind = ICMPK_REQ;
			else if (cap_f16[7:0] == ICMP_ECHO_REP) res.icmp_kind = ICMPK_REP;
		end
		res.ip_protocol = ipv4 ? proto_r : 8'h00;
		res.ttl_byte = ipv4 ? cap_ttl : 8'h00;
		res.ip_header_ok = hok;
		res.src_port = l4 ? cap_f16 : 16'h0000;
		res.dest_port = l4 ? cap_dport : 16'h0000;
		res.tcp_flag_bits = tcp ? cap_flags : 3'b000;
		res.tcp_window = tcp ? cap_window : 16'h0000;
		res.tcp_checksum_ok = tok;
		res.truncated = trunc;
		clear_parser();
		return 1'b1;
	endfunction

	function automatic logic [15:0] sum_span(input int lo, input int hi);
		logic [15:0] s;
		s = '0;
		for (int i = lo; i < hi && i < frame_buf.size(); i++)
			s = csum_add(s, i[0] ? {8'h00, frame_buf[i]} : {frame_buf[i], 8'h00});
		return s;
	endfunction

	task automatic build_raw(input logic [15:0] et, input int len, input logic [7:0] fill,
			input bit rnd);
		frame_buf.delete();
		for (int i = 0; i < len; i++) frame_buf.push_back(rnd ? 8'($urandom) : fill);
		if (len > 12) frame_buf[12] = et[15:8];
		if (len > 13) frame_buf[13] = et[7:0];
	endtask

	task automatic build_arp(input logic [15:0] op, input int len);
		build_raw(ETYPE_ARP, len, 8'h00, 1'b1);
		if (len > 21) begin
			frame_buf[20] = op[15:8];
			frame_buf[21] = op[7:0];
		end
	endtask

	task automatic build_ipv4(input logic [7:0] proto, input logic [3:0] ihl, input int seg_len,
			input int tlen_adj, input int pad, input int cut, input bit hdr_good,
			input bit seg_good, input logic [7:0] l4_byte);
		int hl, tl, base;
		logic [15:0] s;
		hl = (ihl < 4'd5) ? 20 : int'(ihl) * 4;
		tl = hl + seg_len + tlen_adj;
		if (tl < 0) tl = 0;
		if (tl > 65535) tl = 65535;
		frame_buf.delete();
		repeat (12) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(ETYPE_IPV4[15:8]);
		frame_buf.push_back(ETYPE_IPV4[7:0]);
		frame_buf.push_back({4'h4, ihl});
		frame_buf.push_back(8'($urandom));
		frame_buf.push_back(8'(tl >> 8));
		frame_buf.push_back(8'(tl));
		repeat (5) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(proto);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(8'h00);
		repeat (hl - 12) frame_buf.push_back(8'($urandom));
		repeat (seg_len) frame_buf.push_back(8'($urandom));
		base = 14 + hl;
		if (proto == PROTO_ICMP && seg_len > 0) frame_buf[base] = l4_byte;
		if (proto == PROTO_TCP && seg_len > 13) frame_buf[base + 13] = l4_byte;
		if (proto == PROTO_TCP && seg_len > 17) begin
			frame_buf[base + 16] = 8'h00;
			frame_buf[base + 17] = 8'h00;
		end
		s = sum_span(14, base);
		if (!hdr_good) s = s ^ 16'(1 << $urandom_range(0, 15));
		frame_buf[24] = ~s[15:8];
		frame_buf[25] = ~s[7:0];
		if (proto == PROTO_TCP && seg_len > 17 && seg_good) begin
			s = csum_add(sum_span(26, 34), sum_span(base, 14 + tl));
			s = csum_add(s, {8'h00, PROTO_TCP});
			if (tl >= hl) s = csum_add(s, 16'(tl - hl));
			frame_buf[base + 16] = ~s[15:8];
			frame_buf[base + 17] = ~s[7:0];
		end
		repeat (pad) frame_buf.push_back(8'($urandom));
		repeat (cut) if (frame_buf.size() > 1) void'(frame_buf.pop_back());
	endtask

	task automatic send_byte(input logic [7:0] d, input logic l);
		int gap;
		phc_out_t res;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_word <= '{data_byte: d, last_byte: l};
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		bytes_sent++;
		if (classify_byte(d, l, res)) frame_results.push_back(res);
	endtask

	task automatic send_frame();
		foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (frame_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
		if (e !== a) begin
			field_errors++;
			if (field_errors <= 10)
				$display("result %0d %s: expected %0h, got %0h", results_seen, name, e, a);
		end
	endtask

	initial begin
		int stall;
		phc_out_t e, a;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off != 0) begin
				stall = hold_off;
				hold_off = 0;
			end else begin
				stall = idle_on ? $urandom_range(0, 11) : 0;
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			a = result_word;
			results_seen++;
			if (frame_results.size() == 0) begin
				field_errors++;
				if (field_errors <= 10)
					$display("result %0d arrived with no frame outstanding: %p", results_seen, a);
			end else begin
				e = frame_results.pop_front();
				if (e.frame_kind == KIND_ARP) arp_seen++;
				if (e.frame_kind == KIND_IPV4) ipv4_seen++;
				if (e.truncated) trunc_seen++;
				if (e.tcp_checksum_ok) tcp_ok_seen++;
				check_field("frame_kind", 16'(e.frame_kind), 16'(a.frame_kind));
				check_field("arp_op_kind", 16'(e.arp_op_kind), 16'(a.arp_op_kind));
				check_field("ip_protocol", 16'(e.ip_protocol), 16'(a.ip_protocol));
				check_field("ttl_byte", 16'(e.ttl_byte), 16'(a.ttl_byte));
				check_field("ip_header_ok", 16'(e.ip_header_ok), 16'(a.ip_header_ok));
				check_field("icmp_kind", 16'(e.icmp_kind), 16'(a.icmp_kind));
				check_field("src_port", e.src_port, a.src_port);
				check_field("dest_port", e.dest_port, a.dest_port);
				check_field("tcp_flag_bits", 16'(e.tcp_flag_bits), 16'(a.tcp_flag_bits));
				check_field("tcp_window", e.tcp_window, a.tcp_window);
				check_field("tcp_checksum_ok", 16'(e.tcp_checksum_ok),
					16'(a.tcp_checksum_ok));
				check_field("truncated", 16'(e.truncated), 16'(a.truncated));
			end
		end
	end

	task automatic test_short_frames();
		build_raw(16'h0000, 1, 8'h00, 1'b1);
		send_frame();
		build_raw(16'h0000, 13, 8'h00, 1'b1);
		send_frame();
		build_raw(16'h86dd, 14, 8'h00, 1'b1);
		send_frame();
		build_raw(16'h0000, 60, 8'h00, 1'b0);
		send_frame();
		build_raw(16'hffff, 60, 8'hff, 1'b0);
		send_frame();
		drain();
	endtask

	task automatic test_arp();
		build_arp(ARPOP_REQ, 42);
		send_frame();
		build_arp(ARPOP_REP, 60);
		send_frame();
		build_arp(16'h0003, 42);
		send_frame();
		build_arp(16'hffff, 42);
		send_frame();
		build_arp(ARPOP_REQ, 30);
		send_frame();
		drain();
	endtask

	task automatic test_icmp();
		build_ipv4(PROTO_ICMP, 4'd5, 8, 0, 0, 0, 1'b1, 1'b1, ICMP_ECHO_REQ);
		send_frame();
		build_ipv4(PROTO_ICMP, 4'd5, 12, 0, 0, 0, 1'b1, 1'b1, ICMP_ECHO_REP);
		send_frame();
		build_ipv4(PROTO_ICMP, 4'd5, 8, 0, 6, 0, 1'b1, 1'b1, 8'h03);
		send_frame();
		drain();
	endtask

	task automatic test_udp();
		build_ipv4(PROTO_UDP, 4'd5, 12, 0, 0, 0, 1'b1, 1'b1, 8'h00);
		send_frame();
		build_ipv4(PROTO_UDP, 4'd6, 8, 0, 0, 3, 1'b1, 1'b1, 8'h00);
		send_frame();
		drain();
	endtask

	task automatic test_tcp();
		build_ipv4(PROTO_TCP, 4'd5, 20, 0, 0, 0, 1'b1, 1'b1, 8'h07);
		send_frame();
		build_ipv4(PROTO_TCP, 4'd5, 24, 0, 0, 0, 1'b1, 1'b0, 8'h00);
		send_frame();
		build_ipv4(PROTO_TCP, 4'd5, 25, 0, 0, 0, 1'b1, 1'b1, 8'hfa);
		send_frame();
		build_ipv4(PROTO_TCP, 4'd15, 20, 0, 0, 0, 1'b1, 1'b1, 8'h02);
		send_frame();
		build_ipv4(PROTO_TCP, 4'd5, 21, 0, 10, 0, 1'b1, 1'b1, 8'hff);
		send_frame();
		drain();
	endtask

	task automatic test_ip_header();
		build_ipv4(PROTO_UDP, 4'd5, 8, 0, 0, 0, 1'b0, 1'b1, 8'h00);
		send_frame();
		build_ipv4(PROTO_TCP, 4'd0, 20, 0, 0, 0, 1'b1, 1'b1, 8'h01);
		send_frame();
		build_ipv4(PROTO_UDP, 4'd4, 8, 0, 0, 0, 1'b1, 1'b1, 8'h00);
		send_frame();
		build_ipv4(PROTO_UDP, 4'd5, 8, 0, 0, 12, 1'b1, 1'b1, 8'h00);
		send_frame();
		build_ipv4(8'hff, 4'd5, 4, 0, 0, 0, 1'b1, 1'b1, 8'h00);
		send_frame();
		drain();
	endtask

	task automatic test_lengths();
		build_ipv4(PROTO_TCP, 4'd5, 20, -30, 0, 0, 1'b1, 1'b1, 8'h04);
		send_frame();
		build_ipv4(PROTO_TCP, 4'd5, 20, 10, 0, 0, 1'b1, 1'b1, 8'h02);
		send_frame();
		build_ipv4(PROTO_TCP, 4'd5, 30, 0, 0, 15, 1'b1, 1'b1, 8'h06);
		send_frame();
		drain();
	endtask

	task automatic test_backpressure();
		drain();
		idle_on = 1'b0;
		hold_off = 400;
		repeat (12) begin
			build_raw(16'($urandom), 14 + $urandom_range(0, 4), 8'h00, 1'b1);
			send_frame();
		end
		idle_on = 1'b1;
		drain();
	endtask

	task automatic test_random();
		int start_bytes, pick, ihl, hl, seg, adj;
		logic [7:0] proto, l4b;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < 400) begin
			idle_on = $urandom_range(0, 4) != 0;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if (pick < 30) proto = PROTO_TCP;
				else if (pick < 45) proto = PROTO_UDP;
				else if (pick < 60) proto = PROTO_ICMP;
				else proto = 8'($urandom);
				pick = $urandom_range(0, 9);
				if (pick < 6) ihl = 5;
				else if (pick < 8) ihl = $urandom_range(6, 15);
				else ihl = $urandom_range(0, 4);
				hl = (ihl < 5) ? 20 : ihl * 4;
				if (proto == PROTO_TCP)
					seg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : $urandom_range(20, 48);
				else
					seg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 32);
				pick = $urandom_range(0, 9);
				if (pick < 7) adj = 0;
				else if (pick == 7) adj = -int'($urandom_range(1, hl + seg));
				else adj = $urandom_range(1, 16);
				case ($urandom_range(0, 2))
					0: l4b = ICMP_ECHO_REQ;
					1: l4b = ICMP_ECHO_REP;
					default: l4b = 8'($urandom);
				endcase
				if (proto == PROTO_TCP) l4b = 8'($urandom);
				build_ipv4(proto, 4'(ihl), seg, adj,
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0,
					($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : 0,
					$urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0, l4b);
			end else if (pick < 85) begin
				case ($urandom_range(0, 3))
					0: build_arp(ARPOP_REQ, $urandom_range(42, 60));
					1: build_arp(ARPOP_REP, $urandom_range(42, 60));
					2: build_arp(16'($urandom), 42);
					default: build_arp(ARPOP_REQ, $urandom_range(1, 41));
				endcase
			end else if (pick < 95) begin
				build_raw(16'($urandom), $urandom_range(14, 80), 8'h00, 1'b1);
			end else begin
				build_raw(($urandom_range(0, 1) == 0) ? ETYPE_IPV4 : 16'($urandom),
					$urandom_range(1, 40), 8'h00, 1'b1);
			end
			send_frame();
			if ($urandom_range(0, 19) == 0) drain();
		end
		idle_on = 1'b1;
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_frames();
		test_arp();
		test_icmp();
		test_udp();
		test_tcp();
		test_ip_header();
		test_lengths();
		test_backpressure();
		test_random();
		repeat (8) @(posedge clk);
		$display("sent %0d frames in %0d bytes; checked %0d results (%0d arp, %0d ipv4)",
			frames_sent, bytes_sent, results_seen, arp_seen, ipv4_seen);
		$display("short frames flagged: %0d, tcp checksums verified good: %0d, field errors: %0d",
			trunc_seen, tcp_ok_seen, field_errors);
		if (field_errors == 0 && frame_results.size() == 0) begin
			$display("packet_header_classifier regression: pass");
		end else begin
			$display("packet_header_classifier regression: fail");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d results outstanding", frame_results.size());
		$display("packet_header_classifier regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/phc_pkg.sv
sv/phc_parse.sv
sv/phc_finish.sv
sv/packet_header_classifier.sv
dv/tb_top.sv
